@@ sv/rrmv_pkg.sv @@
package rrmv_pkg;

  // field widths
  localparam int PIX_W     = 8;
  localparam int FRAC_W    = 8;
  localparam int MEAN_W    = 16;
  localparam int VAR_W     = 22;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 3;

  // colour channels
  localparam int NUM_CHAN = 3;
  localparam int CHAN_W   = 2;
  localparam logic [CHAN_W-1:0] CHAN_FIRST = 2'd0;
  localparam logic [CHAN_W-1:0] CHAN_LAST  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COL_FIRST    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COL_STOP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_FIRST    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STOP     = 3'd5;

  // register reset values
  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 13'd480;
  localparam logic [CFG_W-1:0] COL_FIRST_RST    = 13'd0;
  localparam logic [CFG_W-1:0] COL_STOP_RST     = 13'd640;
  localparam logic [CFG_W-1:0] ROW_FIRST_RST    = 13'd0;
  localparam logic [CFG_W-1:0] ROW_STOP_RST     = 13'd480;

  // multiplier operand selection
  localparam logic [1:0] MUL_NN = 2'd0;  // count * count
  localparam logic [1:0] MUL_NQ = 2'd1;  // count * sum of squares
  localparam logic [1:0] MUL_SS = 2'd2;  // sum * sum

  // divider operand selection
  localparam logic DIV_MEAN = 1'b0;  // sum * 256 / count
  localparam logic DIV_VAR  = 1'b1;  // numerator * 256 / count^2

  // commands from the controller to the datapath
  typedef struct packed {
    logic              pix_take;
    logic              mul_start;
    logic [1:0]        mul_sel;
    logic              div_start;
    logic              div_sel;
    logic [CHAN_W-1:0] chan;
    logic              cap_nsq;
    logic              cap_prod;
    logic              cap_num;
    logic              cap_mean;
    logic              cap_var;
    logic              out_load;
  } rrmv_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic frame_last;
    logic empty;
    logic mul_busy;
    logic div_busy;
  } rrmv_stat_t;

endpackage

@@ sv/rrmv_mul.sv @@
module rrmv_mul #(
  parameter int AW = 41,
  parameter int BW = 33
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             busy,
  output logic [AW+BW-1:0] p
);

  localparam int PW   = AW + BW;
  localparam int CNTW = $clog2(BW + 1);

  logic [CNTW-1:0] cnt;
  logic [PW-1:0]   acc;
  logic [AW-1:0]   a_r;
  logic [BW-1:0]   b_r;

  // step control: one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNTW'(BW);
    end else if (busy) begin
      cnt <= cnt - CNTW'(1);
      if (cnt == CNTW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // shift and add, multiplier msb first
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      a_r <= a;
      b_r <= b;
    end else if (busy) begin
      acc <= {acc[PW-2:0], 1'b0} + (b_r[BW-1] ? PW'(a_r) : PW'(0));
      b_r <= {b_r[BW-2:0], 1'b0};
    end
  end

  assign p = acc;

endmodule

@@ sv/rrmv_div.sv @@
module rrmv_div #(
  parameter int NW = 74,
  parameter int DW = 50
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [NW-1:0] quotient
);

  localparam int CNTW = $clog2(NW + 1);

  logic [CNTW-1:0] cnt;
  logic [DW-1:0]   rem;
  logic [NW-1:0]   quo;
  logic [DW-1:0]   d_r;
  logic [DW:0]     trial;
  logic [DW:0]     diff;
  logic            fits;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial = {rem, quo[NW-1]};
    diff  = trial - {1'b0, d_r};
    fits  = (trial >= {1'b0, d_r});
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNTW'(NW);
    end else if (busy) begin
      cnt <= cnt - CNTW'(1);
      if (cnt == CNTW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      d_r <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[DW-1:0] : trial[DW-1:0];
      quo <= {quo[NW-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

@@ sv/rrmv_dp.sv @@
module rrmv_dp #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rrmv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rrmv_pkg::CFG_W-1:0]          cfg_data,
  input  logic [rrmv_pkg::PIX_W-1:0]          red,
  input  logic [rrmv_pkg::PIX_W-1:0]          green,
  input  logic [rrmv_pkg::PIX_W-1:0]          blue,
  input  rrmv_pkg::rrmv_cmd_t                 cmd,
  output rrmv_pkg::rrmv_stat_t                stat,
  output logic [rrmv_pkg::MEAN_W-1:0]         mean_red,
  output logic [rrmv_pkg::MEAN_W-1:0]         mean_green,
  output logic [rrmv_pkg::MEAN_W-1:0]         mean_blue,
  output logic [rrmv_pkg::VAR_W-1:0]          var_red,
  output logic [rrmv_pkg::VAR_W-1:0]          var_green,
  output logic [rrmv_pkg::VAR_W-1:0]          var_blue,
  output logic                                region_empty
);

  localparam int CFG_W = rrmv_pkg::CFG_W;
  localparam int PIX_W = rrmv_pkg::PIX_W;
  localparam int NCH   = rrmv_pkg::NUM_CHAN;

  // position widths and compare widths
  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int XMW = $clog2(MAX_WIDTH + 1);
  localparam int YMW = $clog2(MAX_HEIGHT + 1);
  localparam int LW  = ((XMW > CFG_W) ? XMW : CFG_W) + 1;
  localparam int LH  = ((YMW > CFG_W) ? YMW : CFG_W) + 1;

  // accumulator and arithmetic widths
  localparam int CW   = $clog2(longint'(MAX_WIDTH) * longint'(MAX_HEIGHT) + longint'(1));
  localparam int SW   = CW + PIX_W;
  localparam int QW   = CW + 2 * PIX_W;
  localparam int NUMW = CW + QW;
  localparam int DVW  = NUMW + rrmv_pkg::FRAC_W;
  localparam int DSW  = 2 * CW;
  localparam int PRW  = QW + SW;

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [CFG_W-1:0] col_first;
  logic [CFG_W-1:0] col_stop;
  logic [CFG_W-1:0] row_first;
  logic [CFG_W-1:0] row_stop;

  logic [XW-1:0] col;
  logic [YW-1:0] row;
  logic [CW-1:0] count;
  logic [SW-1:0] sum   [NCH];
  logic [QW-1:0] sumsq [NCH];

  logic [PIX_W-1:0]   pix [NCH];
  logic [2*PIX_W-1:0] sq  [NCH];

  logic [LW-1:0] w_cfg, w_eff, col_ext, col_inc;
  logic [LH-1:0] h_cfg, h_eff, row_ext, row_inc;
  logic          row_end;
  logic          frame_end;
  logic          in_region;

  logic [QW-1:0]  mul_a;
  logic [SW-1:0]  mul_b;
  logic [PRW-1:0] mul_p;
  logic           mul_busy;
  logic [DVW-1:0] div_n;
  logic [DSW-1:0] div_d;
  logic [DVW-1:0] div_q;
  logic           div_busy;

  logic [DSW-1:0]               nsq;
  logic [NUMW-1:0]              prod;
  logic [NUMW-1:0]              num;
  logic [rrmv_pkg::MEAN_W-1:0]  mean_q   [NCH];
  logic [rrmv_pkg::VAR_W-1:0]   var_q    [NCH];
  logic [rrmv_pkg::MEAN_W-1:0]  mean_out [NCH];
  logic [rrmv_pkg::VAR_W-1:0]   var_out  [NCH];
  logic                         empty_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= rrmv_pkg::IMAGE_WIDTH_RST;
      image_height <= rrmv_pkg::IMAGE_HEIGHT_RST;
      col_first    <= rrmv_pkg::COL_FIRST_RST;
      col_stop     <= rrmv_pkg::COL_STOP_RST;
      row_first    <= rrmv_pkg::ROW_FIRST_RST;
      row_stop     <= rrmv_pkg::ROW_STOP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rrmv_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        rrmv_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        rrmv_pkg::REG_COL_FIRST:    col_first    <= cfg_data;
        rrmv_pkg::REG_COL_STOP:     col_stop     <= cfg_data;
        rrmv_pkg::REG_ROW_FIRST:    row_first    <= cfg_data;
        rrmv_pkg::REG_ROW_STOP:     row_stop     <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame dimensions, zero counts as one and large values saturate
  always_comb begin
    w_cfg = LW'(image_width);
    h_cfg = LH'(image_height);
    if (w_cfg == LW'(0)) begin
      w_eff = LW'(1);
    end else if (w_cfg > LW'(MAX_WIDTH)) begin
      w_eff = LW'(MAX_WIDTH);
    end else begin
      w_eff = w_cfg;
    end
    if (h_cfg == LH'(0)) begin
      h_eff = LH'(1);
    end else if (h_cfg > LH'(MAX_HEIGHT)) begin
      h_eff = LH'(MAX_HEIGHT);
    end else begin
      h_eff = h_cfg;
    end
  end

  // raster position and region test
  always_comb begin
    col_ext   = LW'(col);
    row_ext   = LH'(row);
    col_inc   = col_ext + LW'(1);
    row_inc   = row_ext + LH'(1);
    row_end   = !(col_inc < w_eff);
    frame_end = row_end && !(row_inc < h_eff);
    in_region = (col_ext >= LW'(col_first)) && (col_ext < LW'(col_stop)) &&
                (row_ext >= LH'(row_first)) && (row_ext < LH'(row_stop));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cmd.pix_take) begin
      if (!row_end) begin
        col <= XW'(col_inc);
      end else begin
        col <= '0;
        if (row_inc < h_eff) begin
          row <= YW'(row_inc);
        end else begin
          row <= '0;
        end
      end
    end
  end

  // pixel squares
  always_comb begin
    pix[0] = red;
    pix[1] = green;
    pix[2] = blue;
    for (int k = 0; k < NCH; k++) begin
      sq[k] = (2*PIX_W)'(pix[k]) * (2*PIX_W)'(pix[k]);
    end
  end

  // region accumulators, cleared when the result is handed over
  always_ff @(posedge clk) begin
    if (rst || cmd.out_load) begin
      count <= '0;
      for (int k = 0; k < NCH; k++) begin
        sum[k]   <= '0;
        sumsq[k] <= '0;
      end
    end else if (cmd.pix_take && in_region) begin
      count <= count + CW'(1);
      for (int k = 0; k < NCH; k++) begin
        sum[k]   <= sum[k] + SW'(pix[k]);
        sumsq[k] <= sumsq[k] + QW'(sq[k]);
      end
    end
  end

  // multiplier operands
  always_comb begin
    case (cmd.mul_sel)
      rrmv_pkg::MUL_NN: begin
        mul_a = QW'(count);
        mul_b = SW'(count);
      end
      rrmv_pkg::MUL_NQ: begin
        mul_a = sumsq[cmd.chan];
        mul_b = SW'(count);
      end
      rrmv_pkg::MUL_SS: begin
        mul_a = QW'(sum[cmd.chan]);
        mul_b = sum[cmd.chan];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // divider operands
  always_comb begin
    case (cmd.div_sel)
      rrmv_pkg::DIV_MEAN: begin
        div_n = DVW'({sum[cmd.chan], {rrmv_pkg::FRAC_W{1'b0}}});
        div_d = DSW'(count);
      end
      rrmv_pkg::DIV_VAR: begin
        div_n = {num, {rrmv_pkg::FRAC_W{1'b0}}};
        div_d = nsq;
      end
      default: begin
        div_n = '0;
        div_d = '0;
      end
    endcase
  end

  rrmv_mul #(
    .AW (QW),
    .BW (SW)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .p     (mul_p)
  );

  rrmv_div #(
    .NW (DVW),
    .DW (DSW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // intermediate products and per channel results
  always_ff @(posedge clk) begin
    if (cmd.cap_nsq) begin
      nsq <= mul_p[DSW-1:0];
    end
    if (cmd.cap_prod) begin
      prod <= mul_p[NUMW-1:0];
    end
    if (cmd.cap_num) begin
      num <= prod - mul_p[NUMW-1:0];
    end
    if (cmd.cap_mean) begin
      mean_q[cmd.chan] <= div_q[rrmv_pkg::MEAN_W-1:0];
    end
    if (cmd.cap_var) begin
      var_q[cmd.chan] <= div_q[rrmv_pkg::VAR_W-1:0];
    end
  end

  // output register, zeros for an empty region
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      empty_out <= (count == CW'(0));
      for (int k = 0; k < NCH; k++) begin
        mean_out[k] <= (count == CW'(0)) ? '0 : mean_q[k];
        var_out[k]  <= (count == CW'(0)) ? '0 : var_q[k];
      end
    end
  end

  assign mean_red     = mean_out[0];
  assign mean_green   = mean_out[1];
  assign mean_blue    = mean_out[2];
  assign var_red      = var_out[0];
  assign var_green    = var_out[1];
  assign var_blue     = var_out[2];
  assign region_empty = empty_out;

  // status to the controller
  always_comb begin
    stat.frame_last = frame_end;
    stat.empty      = (count == CW'(0));
    stat.mul_busy   = mul_busy;
    stat.div_busy   = div_busy;
  end

endmodule

@@ sv/rrmv_ctrl.sv @@
module rrmv_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  rrmv_pkg::rrmv_stat_t stat,
  output rrmv_pkg::rrmv_cmd_t  cmd
);

  localparam logic [3:0] S_PIX     = 4'd0;
  localparam logic [3:0] S_NSQ_GO  = 4'd1;
  localparam logic [3:0] S_NSQ_WT  = 4'd2;
  localparam logic [3:0] S_MEAN_GO = 4'd3;
  localparam logic [3:0] S_MEAN_WT = 4'd4;
  localparam logic [3:0] S_SQ_GO   = 4'd5;
  localparam logic [3:0] S_SQ_WT   = 4'd6;
  localparam logic [3:0] S_SS_GO   = 4'd7;
  localparam logic [3:0] S_SS_WT   = 4'd8;
  localparam logic [3:0] S_VAR_GO  = 4'd9;
  localparam logic [3:0] S_VAR_WT  = 4'd10;
  localparam logic [3:0] S_OUT     = 4'd11;

  logic [3:0]                  state, state_next;
  logic [rrmv_pkg::CHAN_W-1:0] chan, chan_next;

  // sequencer: n^2 once, then mean, n*sumsq, sum^2 and variance per channel; an empty region goes straight to output
  always_comb begin
    state_next = state;
    chan_next  = chan;
    cmd        = '0;
    cmd.chan   = chan;
    case (state)
      S_PIX: begin
        if (in_valid) begin
          cmd.pix_take = 1'b1;
          if (stat.frame_last) begin
            state_next = S_NSQ_GO;
          end
        end
      end
      S_NSQ_GO: begin
        if (stat.empty) begin
          state_next = S_OUT;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = rrmv_pkg::MUL_NN;
          state_next    = S_NSQ_WT;
        end
      end
      S_NSQ_WT: begin
        cmd.mul_sel = rrmv_pkg::MUL_NN;
        if (!stat.mul_busy) begin
          cmd.cap_nsq = 1'b1;
          chan_next   = rrmv_pkg::CHAN_FIRST;
          state_next  = S_MEAN_GO;
        end
      end
      S_MEAN_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = rrmv_pkg::DIV_MEAN;
        state_next    = S_MEAN_WT;
      end
      S_MEAN_WT: begin
        cmd.div_sel = rrmv_pkg::DIV_MEAN;
        if (!stat.div_busy) begin
          cmd.cap_mean = 1'b1;
          state_next   = S_SQ_GO;
        end
      end
      S_SQ_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = rrmv_pkg::MUL_NQ;
        state_next    = S_SQ_WT;
      end
      S_SQ_WT: begin
        cmd.mul_sel = rrmv_pkg::MUL_NQ;
        if (!stat.mul_busy) begin
          cmd.cap_prod = 1'b1;
          state_next   = S_SS_GO;
        end
      end
      S_SS_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = rrmv_pkg::MUL_SS;
        state_next    = S_SS_WT;
      end
      S_SS_WT: begin
        cmd.mul_sel = rrmv_pkg::MUL_SS;
        if (!stat.mul_busy) begin
          cmd.cap_num = 1'b1;
          state_next  = S_VAR_GO;
        end
      end
      S_VAR_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = rrmv_pkg::DIV_VAR;
        state_next    = S_VAR_WT;
      end
      S_VAR_WT: begin
        cmd.div_sel = rrmv_pkg::DIV_VAR;
        if (!stat.div_busy) begin
          cmd.cap_var = 1'b1;
          if (chan == rrmv_pkg::CHAN_LAST) begin
            state_next = S_OUT;
          end else begin
            chan_next  = chan + rrmv_pkg::CHAN_W'(1);
            state_next = S_MEAN_GO;
          end
        end
      end
      S_OUT: begin
        // wait for the output register to be free
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_PIX;
        end
      end
      default: begin
        state_next = S_PIX;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_PIX;
      chan  <= rrmv_pkg::CHAN_FIRST;
    end else begin
      state <= state_next;
      chan  <= chan_next;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign in_stall = (state != S_PIX);

  // checks
  a_mul_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_start |-> !stat.mul_busy)
    else $error("multiplier started while busy");

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !stat.div_busy)
    else $error("divider started while busy");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !cmd.out_load)
    else $error("held result overwritten");

  a_units_idle_when_taking: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !(stat.mul_busy || stat.div_busy))
    else $error("arithmetic unit busy while pixels are taken");

  a_stall_after_frame: assert property (@(posedge clk) disable iff (rst)
    (cmd.pix_take && stat.frame_last) |=> in_stall)
    else $error("pixel taken straight after end of frame");

endmodule

@@ sv/rgb_region_mean_variance_top.sv @@
// Region mean and variance for an RGB stream. Pixels arrive in raster order, one per
// transfer, and the block tracks column and row itself against image_width/image_height.
// Pixels inside [col_first, col_stop) x [row_first, row_stop) are summed per channel
// together with their squares and counted. After the last pixel of a frame one result
// is produced: per channel mean (8.8) and population variance (14.8), both floored, or
// zeros with region_empty set when no pixel fell in the region. Within a frame one pixel
// is taken every cycle. After the last pixel the input stalls while a shared bit-serial
// multiplier and a restoring divider (one bit per cycle) work out the statistics, and
// then until the previous result is no longer held by out_stall; for an empty region
// the arithmetic is skipped. Registers are written through the cfg port, which is
// always ready; write them only between frames.
module rgb_region_mean_variance_top #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rrmv_pkg::PIX_W-1:0]     red,
  input  logic [rrmv_pkg::PIX_W-1:0]     green,
  input  logic [rrmv_pkg::PIX_W-1:0]     blue,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rrmv_pkg::MEAN_W-1:0]    mean_red,
  output logic [rrmv_pkg::MEAN_W-1:0]    mean_green,
  output logic [rrmv_pkg::MEAN_W-1:0]    mean_blue,
  output logic [rrmv_pkg::VAR_W-1:0]     var_red,
  output logic [rrmv_pkg::VAR_W-1:0]     var_green,
  output logic [rrmv_pkg::VAR_W-1:0]     var_blue,
  output logic                           region_empty,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rrmv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rrmv_pkg::CFG_W-1:0]     cfg_data
);

  rrmv_pkg::rrmv_cmd_t  cmd;
  rrmv_pkg::rrmv_stat_t stat;
  logic                 cfg_we;

  // register writes complete on any valid cycle
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  rrmv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  rrmv_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .cmd          (cmd),
    .stat         (stat),
    .mean_red     (mean_red),
    .mean_green   (mean_green),
    .mean_blue    (mean_blue),
    .var_red      (var_red),
    .var_green    (var_green),
    .var_blue     (var_blue),
    .region_empty (region_empty)
  );

endmodule
